// ===== rtl/fdc_pkg.sv =====
// shared types, constants and crc helper for the frame delineator
`default_nettype none
package fdc_pkg;
	localparam int STORE_BYTES   = 64;
	localparam int TABLE_ENTRIES = 8;
	localparam int SYNC_OVERHEAD = 4;
	localparam int STORE_AW      = $clog2(STORE_BYTES);
	localparam int TBL_AW        = $clog2(TABLE_ENTRIES);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_MSB  = 16'h8000;

	localparam logic [1:0] REQ_BYTE = 2'd0;
	localparam logic [1:0] REQ_LOAD = 2'd1;
	localparam logic [1:0] REQ_LINK = 2'd2;

	localparam logic [2:0] REG_CRC_ON     = 3'd0;
	localparam logic [2:0] REG_SYNC_HEAD  = 3'd1;
	localparam logic [2:0] REG_CALL_HEAD  = 3'd2;
	localparam logic [2:0] REG_FAULT_HEAD = 3'd3;
	localparam logic [2:0] REG_REPLY_HEAD = 3'd4;
	localparam logic [2:0] REG_CALL_LEN   = 3'd5;
	localparam logic [2:0] REG_FAULT_LEN  = 3'd6;
	localparam logic [2:0] REG_REPLY_LEN  = 3'd7;

	localparam logic [1:0] KIND_SYNC  = 2'd0;
	localparam logic [1:0] KIND_CALL  = 2'd1;
	localparam logic [1:0] KIND_FAULT = 2'd2;
	localparam logic [1:0] KIND_REPLY = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_FIRST = 2'd1,
		PH_BODY  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_READ,
		ST_LOAD,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic clr_idx;
		logic rd;
		logic load;
		logic load_err;
		logic next;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic bad;
		logic last;
	} stat_t;

	function automatic logic [15:0] crc_upd(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((r & CRC_MSB) != 16'h0000)
				r = (r << 1) ^ CRC_POLY;
			else
				r = r << 1;
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/fdc_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module fdc_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/fdc_ctrl.sv =====
// controller state machine: byte intake and frame emission sequencing
`default_nettype none
module fdc_ctrl import fdc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  wire logic  m_tready,
	input  wire stat_t st,
	output cmd_t       cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && st.done)
					state_d = ST_START;
			end
			ST_START: begin
				cmd.clr_idx = 1'b1;
				if (st.bad) begin
					cmd.load_err = 1'b1;
					state_d = ST_SEND;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_SEND;
			end
			ST_SEND: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (st.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.next = 1'b1;
						state_d  = ST_READ;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/fdc_dp.sv =====
// datapath: config, sync table, header parser, crc, frame store and output register
`default_nettype none
module fdc_dp import fdc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire logic [1:0]  req_type,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [2:0]  entry_slot,
	input  wire logic [15:0] entry_id,
	input  wire logic [5:0]  entry_len,
	input  wire logic        entry_on,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire cmd_t        cmd,
	output stat_t            st,
	output logic [1:0]       frame_kind,
	output logic [7:0]       frame_byte,
	output logic             frame_status,
	output logic             last_flag
);
	logic        crc_on_q;
	logic [15:0] sync_head_q, call_head_q, fault_head_q, reply_head_q;
	logic [6:0]  call_len_q, fault_len_q, reply_len_q;

	logic [15:0] tbl_id_q  [TABLE_ENTRIES];
	logic [5:0]  tbl_len_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] tbl_vld_q;

	phase_t      phase_q;
	logic [1:0]  kind_q;
	logic [6:0]  fill_q;
	logic [7:0]  tgt_q;
	logic [15:0] crc0_q, crc1_q;
	logic [7:0]  prev_q;

	logic [6:0]  cnt_q;
	logic        bad_q;
	logic [1:0]  okind_q;
	logic [6:0]  idx_q;

	logic        we;
	logic [STORE_AW-1:0] waddr;
	logic [7:0]  rdata;

	// parser next values
	phase_t      phase_d;
	logic [1:0]  kind_d;
	logic [6:0]  fill_d;
	logic [7:0]  tgt_d;
	logic [15:0] crc0_d, crc1_d;
	logic        finish;
	logic [15:0] pair;
	logic [1:0]  hkind;
	logic        hhit;
	logic [6:0]  hlen;
	logic [7:0]  extra;
	logic [6:0]  nfill;
	logic        thit;
	logic [5:0]  tlen;
	logic        is_byte;

	assign is_byte = fire && (req_type == REQ_BYTE);
	assign pair    = {rx_byte, prev_q};
	assign extra   = crc_on_q ? 8'd2 : 8'd0;
	assign nfill   = fill_q + 7'd1;

	always_comb begin
		hhit  = 1'b1;
		hkind = KIND_SYNC;
		hlen  = 7'd0;
		if (pair == sync_head_q) begin
			hkind = KIND_SYNC;
		end else if (pair == call_head_q) begin
			hkind = KIND_CALL;
			hlen  = call_len_q;
		end else if (pair == fault_head_q) begin
			hkind = KIND_FAULT;
			hlen  = fault_len_q;
		end else if (pair == reply_head_q) begin
			hkind = KIND_REPLY;
			hlen  = reply_len_q;
		end else begin
			hhit = 1'b0;
		end
	end

	// lowest valid slot wins
	always_comb begin
		thit = 1'b0;
		tlen = '0;
		for (int s = TABLE_ENTRIES - 1; s >= 0; s--) begin
			if (tbl_vld_q[s] && tbl_id_q[s] == pair) begin
				thit = 1'b1;
				tlen = tbl_len_q[s];
			end
		end
	end

	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		fill_d  = fill_q;
		tgt_d   = tgt_q;
		crc0_d  = crc0_q;
		crc1_d  = crc1_q;
		finish  = 1'b0;
		we      = 1'b0;
		waddr   = '0;
		case (phase_q)
			PH_FIRST: begin
				if (!hhit) begin
					we      = 1'b1;
					fill_d  = 7'd1;
					tgt_d   = '0;
					crc0_d  = crc_upd(CRC_INIT, rx_byte);
					crc1_d  = CRC_INIT;
				end else begin
					we      = 1'b1;
					waddr   = STORE_AW'(1);
					fill_d  = 7'd2;
					kind_d  = hkind;
					crc0_d  = crc_upd(crc0_q, rx_byte);
					crc1_d  = crc0_q;
					phase_d = PH_BODY;
					if (hkind != KIND_SYNC) begin
						tgt_d = {1'b0, hlen} + extra;
						if (hlen == 7'd0) begin
							phase_d = PH_IDLE;
							fill_d  = '0;
							tgt_d   = '0;
						end else if (tgt_d <= 8'd2) begin
							finish = 1'b1;
						end
					end
				end
			end
			PH_BODY: begin
				if (fill_q >= 7'(STORE_BYTES)) begin
					phase_d = PH_IDLE;
					fill_d  = '0;
					tgt_d   = '0;
				end else begin
					we     = 1'b1;
					waddr  = fill_q[STORE_AW-1:0];
					fill_d = nfill;
					crc0_d = crc_upd(crc0_q, rx_byte);
					crc1_d = crc0_q;
					if (kind_q == KIND_SYNC && nfill == 7'd4) begin
						if (thit)
							tgt_d = {2'b00, tlen} + 8'(SYNC_OVERHEAD) + extra;
						else
							phase_d = PH_IDLE;
					end
					if (phase_d == PH_BODY && tgt_d != 8'd0 && {1'b0, nfill} >= tgt_d)
						finish = 1'b1;
					if (phase_d == PH_IDLE) begin
						fill_d = '0;
						tgt_d  = '0;
					end
				end
			end
			default: begin
				we      = 1'b1;
				fill_d  = 7'd1;
				phase_d = PH_FIRST;
				crc0_d  = crc_upd(CRC_INIT, rx_byte);
				crc1_d  = CRC_INIT;
			end
		endcase
		if (finish) begin
			phase_d = PH_IDLE;
			tgt_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_on_q     <= 1'b0;
			sync_head_q  <= '0;
			call_head_q  <= '0;
			fault_head_q <= '0;
			reply_head_q <= '0;
			call_len_q   <= '0;
			fault_len_q  <= '0;
			reply_len_q  <= '0;
			tbl_vld_q    <= '0;
			phase_q      <= PH_IDLE;
			kind_q       <= KIND_SYNC;
			fill_q       <= '0;
			tgt_q        <= '0;
			cnt_q        <= '0;
			bad_q        <= 1'b0;
			okind_q      <= KIND_SYNC;
			idx_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CRC_ON:     crc_on_q     <= cfg_data[0];
					REG_SYNC_HEAD:  sync_head_q  <= cfg_data;
					REG_CALL_HEAD:  call_head_q  <= cfg_data;
					REG_FAULT_HEAD: fault_head_q <= cfg_data;
					REG_REPLY_HEAD: reply_head_q <= cfg_data;
					REG_CALL_LEN:   call_len_q   <= cfg_data[6:0];
					REG_FAULT_LEN:  fault_len_q  <= cfg_data[6:0];
					REG_REPLY_LEN:  reply_len_q  <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (fire && req_type == REQ_LOAD && 32'(entry_slot) < TABLE_ENTRIES)
				tbl_vld_q[entry_slot[TBL_AW-1:0]] <= entry_on;
			if (fire && req_type == REQ_LINK) begin
				phase_q <= PH_IDLE;
				fill_q  <= '0;
				tgt_q   <= '0;
			end
			if (is_byte) begin
				phase_q <= phase_d;
				kind_q  <= kind_d;
				fill_q  <= finish ? 7'd0 : fill_d;
				tgt_q   <= tgt_d;
				if (finish) begin
					okind_q <= kind_d;
					bad_q   <= crc_on_q && (crc1_q != pair);
					cnt_q   <= crc_on_q ? fill_d - 7'd2 : fill_d;
				end
			end
			if (cmd.clr_idx)
				idx_q <= '0;
			else if (cmd.next)
				idx_q <= idx_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (is_byte) begin
			crc0_q <= crc0_d;
			crc1_q <= crc1_d;
			prev_q <= rx_byte;
		end
		if (fire && req_type == REQ_LOAD && 32'(entry_slot) < TABLE_ENTRIES) begin
			tbl_id_q[entry_slot[TBL_AW-1:0]]  <= entry_id;
			tbl_len_q[entry_slot[TBL_AW-1:0]] <= entry_len;
		end
		if (cmd.load_err) begin
			frame_kind   <= okind_q;
			frame_byte   <= '0;
			frame_status <= 1'b1;
			last_flag    <= 1'b1;
		end else if (cmd.load) begin
			frame_kind   <= okind_q;
			frame_byte   <= rdata;
			frame_status <= 1'b0;
			last_flag    <= (idx_q + 7'd1 == cnt_q);
		end
	end

	fdc_ram #(.W(8), .D(STORE_BYTES)) u_store (
		.clk   (clk),
		.we    (is_byte && we),
		.waddr (waddr),
		.wdata (rx_byte),
		.re    (cmd.rd),
		.raddr (idx_q[STORE_AW-1:0]),
		.rdata (rdata)
	);

	assign st.done = is_byte && finish;
	assign st.bad  = bad_q;
	assign st.last = bad_q || (idx_q + 7'd1 == cnt_q);
endmodule
`default_nettype wire

// ===== rtl/frame_delineator_crc16.sv =====
// top level of the header/length framed byte receiver with crc16 check
//
// channel  dir  tdata                                   tuser               tlast
// s_*      in   rx_byte,entry_slot,entry_id,entry_len,  req_type            -
//               entry_on
// m_*      out  frame_byte                              frame_kind,status   last_flag
// cfg_*    in   write enable, register index, data      -                   -
//
// s_tready is high only in idle; no input beat is taken while a frame is emitted
// emission: a setup state, then per byte store read, load and send; a bad crc frame
// gives a lone error beat; the frame store ram read is registered; a stalled
// m_tready holds the current beat; reset clears parser, table valid bits and regs
`default_nettype none
module frame_delineator_crc16 import fdc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // rx_byte, entry_slot, entry_id, entry_len, entry_on
	input  wire logic [1:0]  s_tuser,  // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // frame_byte
	output logic [2:0]       m_tuser,  // frame_kind, frame_status
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	cmd_t       cmd;
	stat_t      st;
	logic [1:0] kind;
	logic       status;

	fdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	fdc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (s_tvalid && s_tready),
		.req_type     (s_tuser),
		.rx_byte      (s_tdata[7:0]),
		.entry_slot   (s_tdata[10:8]),
		.entry_id     (s_tdata[26:11]),
		.entry_len    (s_tdata[32:27]),
		.entry_on     (s_tdata[33]),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.st           (st),
		.frame_kind   (kind),
		.frame_byte   (m_tdata),
		.frame_status (status),
		.last_flag    (m_tlast)
	);

	assign m_tuser = {status, kind};
endmodule
`default_nettype wire

// ===== tb/frame_delineator_crc16_tb.sv =====
// self-checking testbench for the header/length framed byte receiver with crc16 check
`default_nettype none
module frame_delineator_crc16_tb;
	import fdc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] KIND_NONE = 3'd4;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       bad;
		logic       last;
	} frame_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;  // rx_byte, entry_slot, entry_id, entry_len, entry_on
	logic [1:0]  s_tuser = '0;  // req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;       // frame_byte
	logic [2:0]  m_tuser;       // frame_kind, frame_status
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	frame_delineator_crc16 i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic        m_crc_on;
	logic [15:0] m_head [1:4];
	logic [6:0]  m_len [5:7];
	logic [1:0]  m_phase;
	logic [2:0]  m_kind;
	int          m_fill, m_target;
	logic [7:0]  m_store [STORE_BYTES];
	logic [15:0] m_ids [TABLE_ENTRIES];
	logic [5:0]  m_lens [TABLE_ENTRIES];
	logic        m_valid [TABLE_ENTRIES];

	frame_beat_t expected_beats [$];
	int errors = 0, beats_seen = 0, frames_good = 0, frames_bad = 0, bytes_sent = 0;
	int beats_sent = 0;
	int idle_cycles = 0;
	bit burst_on = 1'b1;
	int burst_left = 0;
	int stall_mode = 0;

	function automatic logic [15:0] crc_of(int n);
		logic [15:0] c;
		c = 16'hFFFF;
		for (int i = 0; i < n; i++) begin
			c = c ^ {m_store[i], 8'h00};
			for (int b = 0; b < 8; b++)
				c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		end
		return c;
	endfunction

	function automatic void parser_idle();
		m_phase = PH_IDLE;
		m_kind = KIND_NONE;
		m_fill = 0;
		m_target = 0;
	endfunction

	function automatic void emit_frame();
		int n;
		logic [15:0] got;
		frame_beat_t e;
		n = m_fill;
		e.kind = m_kind[1:0];
		if (m_crc_on) begin
			n = n - 2;
			got = {m_store[n + 1], m_store[n]};
			if (got != crc_of(n)) begin
				e.data = 8'h00; e.bad = 1'b1; e.last = 1'b1;
				expected_beats.push_back(e);
				frames_bad++;
				parser_idle();
				return;
			end
		end
		for (int i = 0; i < n; i++) begin
			e.data = m_store[i]; e.bad = 1'b0; e.last = (i == n - 1);
			expected_beats.push_back(e);
		end
		frames_good++;
		parser_idle();
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		logic [15:0] hd, id;
		int extra, len;
		bit hit;
		extra = m_crc_on ? 2 : 0;
		if (m_phase == PH_FIRST) begin
			m_store[1] = b;
			m_fill = 2;
			hd = {b, m_store[0]};
			if (hd == m_head[REG_SYNC_HEAD]) m_kind = {1'b0, KIND_SYNC};
			else if (hd == m_head[REG_CALL_HEAD]) m_kind = {1'b0, KIND_CALL};
			else if (hd == m_head[REG_FAULT_HEAD]) m_kind = {1'b0, KIND_FAULT};
			else if (hd == m_head[REG_REPLY_HEAD]) m_kind = {1'b0, KIND_REPLY};
			else begin
				m_store[0] = b;
				m_fill = 1;
				m_kind = KIND_NONE;
				return;
			end
			if (m_kind[1:0] != KIND_SYNC) begin
				len = m_kind[1:0] == KIND_CALL ? m_len[REG_CALL_LEN] :
					m_kind[1:0] == KIND_FAULT ? m_len[REG_FAULT_LEN] : m_len[REG_REPLY_LEN];
				if (len == 0) begin
					parser_idle();
					return;
				end
				m_target = len + extra;
				if (m_fill >= m_target) begin
					emit_frame();
					return;
				end
			end
			m_phase = PH_BODY;
		end else if (m_phase == PH_BODY) begin
			if (m_fill >= STORE_BYTES) begin
				parser_idle();
				return;
			end
			m_store[m_fill] = b;
			m_fill++;
			if (m_kind[1:0] == KIND_SYNC && m_fill == 4) begin
				id = {m_store[3], m_store[2]};
				hit = 1'b0;
				for (int s = 0; s < TABLE_ENTRIES && !hit; s++)
					if (m_valid[s] && m_ids[s] == id) begin
						m_target = m_lens[s] + SYNC_OVERHEAD + extra;
						hit = 1'b1;
					end
				if (!hit) begin
					parser_idle();
					return;
				end
			end
			if (m_target > 0 && m_fill >= m_target)
				emit_frame();
		end else begin
			m_store[0] = b;
			m_fill = 1;
			m_phase = PH_FIRST;
		end
	endfunction

	// drives one beat, honoring the burst/gap pattern
	task automatic send_beat(logic [1:0] req, logic [7:0] b, logic [2:0] slot = 3'd0,
			logic [15:0] id = 16'h0000, logic [5:0] len = 6'd0, logic on = 1'b0);
		while (!burst_on) begin
			@(negedge clk);
			if (burst_left == 0) begin
				burst_on = 1'b1;
				burst_left = $urandom_range(1, 20);
			end else
				burst_left--;
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {6'd0, on, len, id, slot, b};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		beats_sent++;
		if (req == REQ_BYTE) begin
			predict_byte(b);
			bytes_sent++;
		end else if (req == REQ_LOAD) begin
			m_ids[slot] = id;
			m_lens[slot] = len;
			m_valid[slot] = on;
		end else if (req == REQ_LINK)
			parser_idle();
		@(negedge clk);
		if (burst_left == 0) begin
			burst_on = ($urandom_range(0, 2) == 0);
			burst_left = burst_on ? $urandom_range(1, 20) : $urandom_range(1, 6);
		end else
			burst_left--;
		if (!burst_on) s_tvalid <= 1'b0;
	endtask

	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (expected_beats.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CRC_ON) m_crc_on = v[0];
		else if (idx <= REG_REPLY_HEAD) m_head[idx] = v;
		else m_len[idx] = v[6:0];
	endtask

	task automatic set_config(logic crc, logic [15:0] sh, logic [15:0] ch, logic [15:0] fh,
			logic [15:0] rh, logic [6:0] cl, logic [6:0] fl, logic [6:0] rl);
		quiesce();
		write_reg(REG_CRC_ON, {15'd0, crc});
		write_reg(REG_SYNC_HEAD, sh);
		write_reg(REG_CALL_HEAD, ch);
		write_reg(REG_FAULT_HEAD, fh);
		write_reg(REG_REPLY_HEAD, rh);
		write_reg(REG_CALL_LEN, {9'd0, cl});
		write_reg(REG_FAULT_LEN, {9'd0, fl});
		write_reg(REG_REPLY_LEN, {9'd0, rl});
	endtask

	// sends a frame, with the right crc when crc is on, or a broken one when corrupt is also set
	task automatic send_frame(logic [15:0] hd, int body, logic [15:0] id, bit corrupt);
		logic [7:0] f [$];
		logic [15:0] c;
		f.push_back(hd[7:0]);
		f.push_back(hd[15:8]);
		if (id !== 16'hxxxx) begin
			f.push_back(id[7:0]);
			f.push_back(id[15:8]);
		end
		while (f.size() < body) f.push_back(8'($urandom));
		if (m_crc_on) begin
			c = 16'hFFFF;
			foreach (f[i]) begin
				c = c ^ {f[i], 8'h00};
				for (int b = 0; b < 8; b++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
			end
			if (corrupt) c = c ^ (16'h1 << $urandom_range(0, 15));
			f.push_back(c[7:0]);
			f.push_back(c[15:8]);
		end
		foreach (f[i]) send_beat(REQ_BYTE, f[i]);
	endtask

	task automatic test_directed();
		set_config(1'b0, 16'hA55A, 16'h0000, 16'hFFFF, 16'h1234, 7'd1, 7'd0, 7'd64);
		send_beat(REQ_LOAD, 8'h00, 3'd0, 16'hFFFF, 6'd60, 1'b1);
		send_beat(REQ_LOAD, 8'h00, 3'd7, 16'h0000, 6'd0, 1'b1);
		send_beat(REQ_LOAD, 8'h00, 3'd1, 16'h0000, 6'd2, 1'b1);
		send_beat(REQ_BYTE, 8'h00);              // call of length 1
		send_beat(REQ_BYTE, 8'h00);
		send_beat(REQ_BYTE, 8'hFF);              // fault of zero length
		send_beat(REQ_BYTE, 8'hFF);
		send_beat(REQ_BYTE, 8'h77);              // unknown header, resync
		send_beat(REQ_BYTE, 8'h5A);
		send_beat(REQ_BYTE, 8'hA5);              // sync, id 0 duplicate slots
		send_beat(REQ_BYTE, 8'h00);
		send_beat(REQ_BYTE, 8'h00);
		send_beat(REQ_BYTE, 8'h80);
		send_beat(REQ_BYTE, 8'h5A);              // closes the sync frame; the next bytes find no header
		send_beat(REQ_BYTE, 8'hA5);
		send_beat(REQ_BYTE, 8'h01);
		send_beat(REQ_BYTE, 8'h02);
		send_beat(REQ_BYTE, 8'h34);              // reply then link event
		send_beat(REQ_BYTE, 8'h12);
		send_beat(REQ_LINK, 8'h00);
		send_beat(REQ_SPARE, 8'hFF, 3'd7, 16'hFFFF, 6'd63, 1'b1);
		send_beat(REQ_BYTE, 8'h00);
		send_beat(REQ_BYTE, 8'h00);
	endtask

	task automatic test_overflow();
		// reply length 64 plus crc cannot fit; sync of 60+4 fills the store exactly
		set_config(1'b1, 16'hA55A, 16'h0000, 16'hFFFF, 16'h1234, 7'd1, 7'd0, 7'd64);
		send_frame(16'h1234, 64, 16'hxxxx, 1'b0);
		send_frame(16'h0000, 1, 16'hxxxx, 1'b0);
		set_config(1'b0, 16'hA55A, 16'h0000, 16'hFFFF, 16'h1234, 7'd1, 7'd0, 7'd64);
		send_frame(16'hA55A, 64, 16'hFFFF, 1'b0);
	endtask

	task automatic test_random(bit crc, int n);
		logic [15:0] hs [4];
		int lens [4];
		int start, pick;
		for (int i = 0; i < 4; i++) hs[i] = 16'($urandom);
		lens[0] = 0;
		for (int i = 1; i < 4; i++) lens[i] = $urandom_range(0, 10) == 0 ? 0 : $urandom_range(1, 12);
		set_config(crc, hs[0], hs[1], hs[2], hs[3], 7'(lens[1]), 7'(lens[2]), 7'(lens[3]));
		start = beats_sent;
		for (int s = 0; s < TABLE_ENTRIES; s++)
			send_beat(REQ_LOAD, 8'h00, 3'(s), 16'($urandom), 6'($urandom_range(0, 8)),
				$urandom_range(0, 3) != 0);
		while (beats_sent - start < n) begin
			pick = $urandom_range(0, 19);
			if (pick < 4) begin
				if (pick == 0)
					send_frame(hs[0], 4 + m_lens[$urandom_range(0, 7)],
						m_ids[$urandom_range(0, 7)], $urandom_range(0, 5) == 0);
				else
					send_frame(hs[pick], lens[pick], 16'hxxxx, $urandom_range(0, 5) == 0);
			end else if (pick < 7) begin
				send_beat(REQ_BYTE, 8'($urandom));
			end else if (pick == 7) begin
				send_beat(REQ_LOAD, 8'h00, 3'($urandom), 16'($urandom), 6'($urandom),
					1'($urandom));
			end else if (pick == 8) begin
				send_beat(2'($urandom_range(2, 3)), 8'($urandom));
			end else if (pick == 9) begin
				quiesce();
				send_frame(hs[1], lens[1], 16'hxxxx, 1'b0);
			end
		end
	endtask

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		frame_beat_t a, e;
		if (m_tvalid && m_tready) begin
			idle_cycles = 0;
			beats_seen++;
			a = {m_tuser[1:0], m_tdata, m_tuser[2], m_tlast};
			if (expected_beats.size() == 0) begin
				$error("unexpected beat kind=%0d byte=%0h", a.kind, a.data);
				errors++;
			end else begin
				e = expected_beats.pop_front();
				if (a.kind !== e.kind) begin
					$error("frame_kind expected %0d actual %0d", e.kind, a.kind); errors++;
				end
				if (a.data !== e.data) begin
					$error("frame_byte expected %0h actual %0h", e.data, a.data); errors++;
				end
				if (a.bad !== e.bad) begin
					$error("frame_status expected %0d actual %0d", e.bad, a.bad); errors++;
				end
				if (a.last !== e.last) begin
					$error("last_flag expected %0d actual %0d", e.last, a.last); errors++;
				end
			end
		end else if (s_tvalid && s_tready)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > 2000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 3) != 0;
			default: m_tready <= $urandom_range(0, 3) == 0;
		endcase
	end

	initial begin
		m_crc_on = 0;
		for (int i = 1; i <= 4; i++) m_head[i] = 0;
		for (int i = 5; i <= 7; i++) m_len[i] = 0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			m_valid[i] = 0; m_ids[i] = 0; m_lens[i] = 0;
		end
		for (int i = 0; i < STORE_BYTES; i++) m_store[i] = 0;
		parser_idle();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_overflow();
		test_random(1'b0, 50);
		test_random(1'b1, 50);
		quiesce();
		repeat (200) @(negedge clk);
		$display("covered %0d stream bytes, %0d good frames, %0d crc failures, %0d beats out",
			bytes_sent, frames_good, frames_bad, beats_seen);
		$display("with crc on and off, resync, drops, overflow, table updates and link events");
		if (errors == 0 && expected_beats.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
